// ----- design/ppg_pkg.sv -----
// ============================================================================
// ppg_pkg: shared types and constants for the packet pacing gate
// Holds the transaction payload structs, the controller/datapath command and
// status bundles, the configuration register indexes and the command codes.
// ============================================================================
`default_nettype none

package ppg_pkg;

    // Field widths of the transactions and configuration registers.
    localparam int unsigned LINE_RATE_W  = 39;
    localparam int unsigned FRAME_W      = 15;
    localparam int unsigned RATE_W       = 14;
    localparam int unsigned CFG_IDX_W    = 2;
    localparam int unsigned CFG_DATA_W   = LINE_RATE_W;
    localparam int unsigned TIME_W       = 64;
    localparam int unsigned COUNT_W      = 16;
    localparam int unsigned BYTES_W      = 32;
    localparam int unsigned STAT_W       = 64;

    // Interval arithmetic widths.
    localparam int unsigned DIV_W        = LINE_RATE_W + RATE_W;
    localparam int unsigned INT_W        = 30;
    localparam int unsigned BATCH_W      = INT_W + COUNT_W;
    localparam int unsigned WIRE_BYTES_W = 16;
    localparam int unsigned WIRE_W       = WIRE_BYTES_W + 3;

    // Arithmetic constants.
    localparam longint unsigned ONE_SECOND_NS  = 64'd1000000000;
    localparam longint unsigned HUNDREDTHS_ALL = 64'd10000;

    // Defaults for the top-level parameters.
    localparam int unsigned OVERRUN_FACTOR_DEF      = 10;
    localparam int unsigned WIRE_OVERHEAD_BYTES_DEF = 20;

    // Configuration register reset values.
    localparam logic [LINE_RATE_W-1:0] LINE_RATE_RST = 39'd10000000000;
    localparam logic [FRAME_W-1:0]     FRAME_RST     = 15'd64;
    localparam logic [RATE_W-1:0]      RATE_RST      = 14'd10000;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_LINE_RATE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME     = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_RATE      = 2'd2;

    // Input command codes.
    localparam logic [1:0] CMD_PACE    = 2'd0;
    localparam logic [1:0] CMD_RECORD  = 2'd1;
    localparam logic [1:0] CMD_RESTART = 2'd2;
    localparam logic [1:0] CMD_NOP     = 2'd3;

    // Divider operand selection.
    localparam logic [1:0] DIV_SEL_PPS      = 2'd0;
    localparam logic [1:0] DIV_SEL_INTERVAL = 2'd1;

    typedef struct packed {
        logic [1:0]         command;
        logic [TIME_W-1:0]  now_ns;
        logic [COUNT_W-1:0] count;
        logic [BYTES_W-1:0] byte_count;
    } in_item_t;

    typedef struct packed {
        logic [TIME_W-1:0] release_ns;
        logic              waited;
        logic              overran;
        logic [STAT_W-1:0] delay_total;
        logic [STAT_W-1:0] overrun_total;
        logic [STAT_W-1:0] packets_total;
        logic [STAT_W-1:0] bytes_total;
    } out_item_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic       load_prod;
        logic       div_start;
        logic [1:0] div_sel;
        logic       cap_pps;
        logic       cap_interval;
        logic       set_default;
        logic       load_in;
        logic       calc_batch;
        logic       calc_scale;
        logic       calc_limit;
        logic       finish;
    } ctrl_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic div_done;
        logic wire_zero;
        logic pps_zero;
        logic out_free;
    } dp_status_t;

endpackage

`default_nettype wire

// ----- design/ppg_divider.sv -----
// ============================================================================
// ppg_divider: serial restoring divider
// Unsigned division, one quotient bit per cycle.
// A start reloads the operands at any time and abandons a running operation.
// ============================================================================
`default_nettype none

module ppg_divider (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      start,
    input  wire logic [ppg_pkg::DIV_W-1:0] dividend,
    input  wire logic [ppg_pkg::DIV_W-1:0] divisor,
    output logic                           done,
    output logic [ppg_pkg::DIV_W-1:0]      quotient
);
    import ppg_pkg::*;

    localparam int unsigned CNT_W = $clog2(DIV_W);

    logic [DIV_W-1:0] rem_reg, rem_next;
    logic [DIV_W-1:0] quo_reg, quo_next;
    logic [DIV_W-1:0] dvs_reg;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic [DIV_W:0]   trial;
    logic [DIV_W:0]   diff;
    logic             last_step;

    // One restoring step: shift in the next dividend bit and try a subtract.
    assign trial     = {rem_reg, quo_reg[DIV_W-1]};
    assign diff      = trial - {1'b0, dvs_reg};
    assign last_step = (cnt_reg == CNT_W'(DIV_W - 1));

    always_comb
    begin
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            rem_next  = '0;
            quo_next  = dividend;
            cnt_next  = '0;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (!diff[DIV_W])
            begin
                rem_next = diff[DIV_W-1:0];
                quo_next = {quo_reg[DIV_W-2:0], 1'b1};
            end
            else
            begin
                rem_next = trial[DIV_W-1:0];
                quo_next = {quo_reg[DIV_W-2:0], 1'b0};
            end
            cnt_next = cnt_reg + 1'b1;
            if (last_step)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    // Operand and partial result registers.
    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        if (start)
        begin
            dvs_reg <= divisor;
        end
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

`default_nettype wire

// ----- design/ppg_datapath.sv -----
// ============================================================================
// ppg_datapath: configuration, interval and pacing datapath
// Holds the configuration registers, derives the packet interval through the
// serial divider, runs the pacing arithmetic and holds the statistics and the
// result register.
// ============================================================================
`default_nettype none

module ppg_datapath #(
    parameter int unsigned OVERRUN_FACTOR      = ppg_pkg::OVERRUN_FACTOR_DEF,
    parameter int unsigned WIRE_OVERHEAD_BYTES = ppg_pkg::WIRE_OVERHEAD_BYTES_DEF
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           cfg_wr_en,
    input  wire logic [ppg_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [ppg_pkg::CFG_DATA_W-1:0] cfg_data,
    input  wire ppg_pkg::in_item_t              in_data,
    input  wire logic                           out_ready,
    output logic                                out_valid,
    output ppg_pkg::out_item_t                  out_data,
    input  wire ppg_pkg::ctrl_cmd_t             cmd,
    output ppg_pkg::dp_status_t                 status
);
    import ppg_pkg::*;

    localparam int unsigned FACT_W  = $clog2(OVERRUN_FACTOR + 1);
    localparam int unsigned SCALE_W = BATCH_W + FACT_W;

    // Saturating 64-bit add.
    function automatic logic [TIME_W-1:0] sat_add(input logic [TIME_W-1:0] a,
                                                   input logic [TIME_W-1:0] b);
        logic [TIME_W:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[TIME_W] ? {TIME_W{1'b1}} : s[TIME_W-1:0];
    endfunction

    logic [LINE_RATE_W-1:0] line_rate_reg;
    logic [FRAME_W-1:0]     frame_reg;
    logic [RATE_W-1:0]      rate_reg;

    logic [DIV_W-1:0]   prod_reg;
    logic [DIV_W-1:0]   pps_reg;
    logic [INT_W-1:0]   interval_reg;
    logic [WIRE_W-1:0]  wire_bits;
    logic [DIV_W-1:0]   div_dividend;
    logic [DIV_W-1:0]   div_divisor;
    logic               div_done;
    logic [DIV_W-1:0]   div_quotient;

    in_item_t           in_reg;
    logic [BATCH_W-1:0] batch_reg;
    logic [SCALE_W-1:0] scale_reg;
    logic [TIME_W-1:0]  limit_reg;
    logic [TIME_W-1:0]  adv_next_reg;
    logic [TIME_W-1:0]  adv_now_reg;

    logic [TIME_W-1:0]  next_rel_reg, next_rel_next;
    logic [STAT_W-1:0]  delay_reg, delay_next;
    logic [STAT_W-1:0]  overrun_reg, overrun_next;
    logic [STAT_W-1:0]  packets_reg, packets_next;
    logic [STAT_W-1:0]  bytes_reg, bytes_next;
    out_item_t          out_reg, out_next;
    logic               out_valid_reg;

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            line_rate_reg <= LINE_RATE_RST;
            frame_reg     <= FRAME_RST;
            rate_reg      <= RATE_RST;
        end
        else if (cfg_wr_en)
        begin
            case (cfg_index)
                CFG_LINE_RATE: line_rate_reg <= cfg_data;
                CFG_FRAME:     frame_reg     <= cfg_data[FRAME_W-1:0];
                CFG_RATE:      rate_reg      <= cfg_data[RATE_W-1:0];
                default:       ;
            endcase
        end
    end

    // Wire size of one frame in bits.
    assign wire_bits = {WIRE_BYTES_W'(frame_reg) + WIRE_BYTES_W'(WIRE_OVERHEAD_BYTES), 3'b000};

    // Divider operand selection. Packets per second come from one division:
    // truncating by ten thousand and then by the wire bits equals a single
    // truncating division by their product.
    always_comb
    begin
        case (cmd.div_sel)
            DIV_SEL_INTERVAL:
            begin
                div_dividend = DIV_W'(ONE_SECOND_NS);
                div_divisor  = pps_reg;
            end
            default:
            begin
                div_dividend = prod_reg;
                div_divisor  = DIV_W'(wire_bits) * DIV_W'(HUNDREDTHS_ALL);
            end
        endcase
    end

    ppg_divider u_divider (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .done     (div_done),
        .quotient (div_quotient)
    );

    // Interval derivation registers.
    always_ff @(posedge clk)
    begin
        if (cmd.load_prod)
        begin
            prod_reg <= DIV_W'(line_rate_reg) * DIV_W'(rate_reg);
        end
        if (cmd.cap_pps)
        begin
            pps_reg <= div_quotient;
        end
        if (cmd.cap_interval)
        begin
            interval_reg <= div_quotient[INT_W-1:0];
        end
        else if (cmd.set_default)
        begin
            interval_reg <= INT_W'(ONE_SECOND_NS);
        end
    end

    // Pacing pipeline registers: batch, scaled batch, then limit and advances.
    always_ff @(posedge clk)
    begin
        if (cmd.load_in)
        begin
            in_reg <= in_data;
        end
        if (cmd.calc_batch)
        begin
            batch_reg <= BATCH_W'(interval_reg) * BATCH_W'(in_reg.count);
        end
        if (cmd.calc_scale)
        begin
            scale_reg <= SCALE_W'(batch_reg) * SCALE_W'(OVERRUN_FACTOR);
        end
        if (cmd.calc_limit)
        begin
            limit_reg    <= sat_add(next_rel_reg, TIME_W'(scale_reg));
            adv_next_reg <= sat_add(next_rel_reg, TIME_W'(batch_reg));
            adv_now_reg  <= sat_add(in_reg.now_ns, TIME_W'(batch_reg));
        end
    end

    // Final step: schedule decision, statistics update and result fields.
    always_comb
    begin
        next_rel_next = next_rel_reg;
        delay_next    = delay_reg;
        overrun_next  = overrun_reg;
        packets_next  = packets_reg;
        bytes_next    = bytes_reg;
        out_next      = '0;
        case (in_reg.command)
            CMD_PACE:
            begin
                out_next.release_ns = in_reg.now_ns;
                if (in_reg.now_ns < next_rel_reg)
                begin
                    delay_next          = delay_reg + 1'b1;
                    out_next.waited     = 1'b1;
                    out_next.release_ns = next_rel_reg;
                    next_rel_next       = adv_next_reg;
                end
                else if (in_reg.now_ns > limit_reg)
                begin
                    overrun_next     = overrun_reg + 1'b1;
                    out_next.overran = 1'b1;
                    next_rel_next    = adv_now_reg;
                end
                else
                begin
                    next_rel_next = adv_next_reg;
                end
            end
            CMD_RECORD:
            begin
                packets_next = packets_reg + STAT_W'(in_reg.count);
                bytes_next   = bytes_reg + STAT_W'(in_reg.byte_count);
            end
            CMD_RESTART:
            begin
                next_rel_next = in_reg.now_ns;
                delay_next    = '0;
                overrun_next  = '0;
                packets_next  = '0;
                bytes_next    = '0;
            end
            default:
            begin
            end
        endcase
        out_next.delay_total   = delay_next;
        out_next.overrun_total = overrun_next;
        out_next.packets_total = packets_next;
        out_next.bytes_total   = bytes_next;
    end

    // Schedule and statistics state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            next_rel_reg <= '0;
            delay_reg    <= '0;
            overrun_reg  <= '0;
            packets_reg  <= '0;
            bytes_reg    <= '0;
        end
        else if (cmd.finish)
        begin
            next_rel_reg <= next_rel_next;
            delay_reg    <= delay_next;
            overrun_reg  <= overrun_next;
            packets_reg  <= packets_next;
            bytes_reg    <= bytes_next;
        end
    end

    // Result register and its valid flag.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.finish)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.finish)
        begin
            out_reg <= out_next;
        end
    end

    assign out_valid        = out_valid_reg;
    assign out_data         = out_reg;
    assign status.div_done  = div_done;
    assign status.wire_zero = (wire_bits == '0);
    assign status.pps_zero  = (pps_reg == '0);
    assign status.out_free  = !out_valid_reg || out_ready;

endmodule

`default_nettype wire

// ----- design/ppg_ctrl.sv -----
// ============================================================================
// ppg_ctrl: packet pacing gate controller
// Sequences the interval derivation after reset and after every configuration
// write, then steps each accepted transaction through the pacing datapath.
// ============================================================================
`default_nettype none

module ppg_ctrl (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               cfg_wr_en,
    input  wire logic               in_valid,
    output logic                    in_ready,
    input  wire ppg_pkg::dp_status_t status,
    output ppg_pkg::ctrl_cmd_t      cmd
);
    import ppg_pkg::*;

    localparam logic [3:0] S_PROD     = 4'd0;
    localparam logic [3:0] S_DIV_PPS  = 4'd1;
    localparam logic [3:0] S_WAIT_PPS = 4'd2;
    localparam logic [3:0] S_DIV_INT  = 4'd3;
    localparam logic [3:0] S_WAIT_INT = 4'd4;
    localparam logic [3:0] S_IDLE     = 4'd5;
    localparam logic [3:0] S_BATCH    = 4'd6;
    localparam logic [3:0] S_SCALE    = 4'd7;
    localparam logic [3:0] S_LIMIT    = 4'd8;
    localparam logic [3:0] S_FINISH   = 4'd9;

    logic [3:0] state_reg, state_next;

    // Next state and datapath commands.
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        cmd.div_sel = DIV_SEL_PPS;
        case (state_reg)
            S_PROD:
            begin
                cmd.load_prod = 1'b1;
                state_next    = S_DIV_PPS;
            end
            S_DIV_PPS:
            begin
                if (status.wire_zero)
                begin
                    cmd.set_default = 1'b1;
                    state_next      = S_IDLE;
                end
                else
                begin
                    cmd.div_start = 1'b1;
                    cmd.div_sel   = DIV_SEL_PPS;
                    state_next    = S_WAIT_PPS;
                end
            end
            S_WAIT_PPS:
            begin
                if (status.div_done)
                begin
                    cmd.cap_pps = 1'b1;
                    state_next  = S_DIV_INT;
                end
            end
            S_DIV_INT:
            begin
                if (status.pps_zero)
                begin
                    cmd.set_default = 1'b1;
                    state_next      = S_IDLE;
                end
                else
                begin
                    cmd.div_start = 1'b1;
                    cmd.div_sel   = DIV_SEL_INTERVAL;
                    state_next    = S_WAIT_INT;
                end
            end
            S_WAIT_INT:
            begin
                if (status.div_done)
                begin
                    cmd.cap_interval = 1'b1;
                    state_next       = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load_in = 1'b1;
                    state_next  = S_BATCH;
                end
            end
            S_BATCH:
            begin
                cmd.calc_batch = 1'b1;
                state_next     = S_SCALE;
            end
            S_SCALE:
            begin
                cmd.calc_scale = 1'b1;
                state_next     = S_LIMIT;
            end
            S_LIMIT:
            begin
                cmd.calc_limit = 1'b1;
                state_next     = S_FINISH;
            end
            S_FINISH:
            begin
                if (status.out_free)
                begin
                    cmd.finish = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_PROD;
            end
        endcase
        // A configuration write restarts the interval derivation.
        if (cfg_wr_en)
        begin
            state_next = S_PROD;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_PROD;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign in_ready = (state_reg == S_IDLE);

endmodule

`default_nettype wire

// ----- design/packet_pacing_gate.sv -----
// ============================================================================
// packet_pacing_gate: transmit pacer with inter-packet interval derivation
// Derives the per-packet interval from line rate, frame size and target rate,
// paces batches against a release schedule and keeps transmit statistics.
// ============================================================================
//
//   Channel   Signals                          Direction  Transaction
//   -------   -------------------------------  ---------  ---------------------
//   cfg       cfg_wr_en, cfg_index, cfg_data    in         register write
//   in        in_valid, in_ready, in_data       in         command request
//   out       out_valid, out_ready, out_data    out        pacing result
//
// Each accepted transaction steps through the multiply by the batch count, the
// multiply by the overrun factor, the saturating limit adds and the final
// schedule update in that order; a new one is taken only once the last has
// finished its final step.
// After reset and after any configuration write the interval is rederived by
// at most two passes of the 53-step serial divider, with in_ready low. A
// result waiting in the output register holds the final step; the input
// side takes no new transaction while it waits.
//
`default_nettype none

module packet_pacing_gate #(
    parameter int unsigned OVERRUN_FACTOR      = ppg_pkg::OVERRUN_FACTOR_DEF,
    parameter int unsigned WIRE_OVERHEAD_BYTES = ppg_pkg::WIRE_OVERHEAD_BYTES_DEF
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           cfg_wr_en,
    input  wire logic [ppg_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [ppg_pkg::CFG_DATA_W-1:0] cfg_data,
    input  wire logic                           in_valid,
    output logic                                in_ready,
    input  wire ppg_pkg::in_item_t              in_data,
    output logic                                out_valid,
    input  wire logic                           out_ready,
    output ppg_pkg::out_item_t                  out_data
);
    import ppg_pkg::*;

    ctrl_cmd_t  cmd;
    dp_status_t status;

    // Sequencing.
    ppg_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wr_en (cfg_wr_en),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .status    (status),
        .cmd       (cmd)
    );

    // Arithmetic, state and result register.
    ppg_datapath #(
        .OVERRUN_FACTOR      (OVERRUN_FACTOR),
        .WIRE_OVERHEAD_BYTES (WIRE_OVERHEAD_BYTES)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_data   (in_data),
        .out_ready (out_ready),
        .out_valid (out_valid),
        .out_data  (out_data),
        .cmd       (cmd),
        .status    (status)
    );

endmodule

`default_nettype wire

// ----- sim/tb_packet_pacing_gate.sv -----
// ============================================================================
// tb_packet_pacing_gate: self-checking testbench for the packet pacing gate
// Drives pace, record, restart and no-op transactions through the valid/ready
// channels under several rate settings. A scoreboard class predicts every
// result from its own copy of the schedule and statistics, and compares each
// returned transaction field by field with the oldest prediction.
// ============================================================================

module tb_packet_pacing_gate;
    timeunit 1ns;
    timeprecision 1ps;

    import ppg_pkg::*;

    // Scoreboard: tracks the configuration, the release schedule and the
    // statistics, and holds the predicted results in arrival order.
    class pacing_checker;
        logic [LINE_RATE_W-1:0] line_rate;
        logic [FRAME_W-1:0]     frame_len;
        logic [RATE_W-1:0]      rate_share;
        logic [63:0]            schedule_ns;
        logic [63:0]            delay_cnt;
        logic [63:0]            overrun_cnt;
        logic [63:0]            packet_cnt;
        logic [63:0]            byte_cnt;
        out_item_t              pending_outcomes[$];
        int                     faults;
        int                     n_pace;
        int                     n_record;
        int                     n_restart;
        int                     n_nop;
        int                     n_waited;
        int                     n_resync;
        int                     n_settings;

        function new();
            line_rate   = LINE_RATE_RST;
            frame_len   = FRAME_RST;
            rate_share  = RATE_RST;
            schedule_ns = '0;
            delay_cnt   = '0;
            overrun_cnt = '0;
            packet_cnt  = '0;
            byte_cnt    = '0;
        endfunction

        function void set_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
            case (idx)
                CFG_LINE_RATE: line_rate = value;
                CFG_FRAME:     frame_len = value[FRAME_W-1:0];
                CFG_RATE:      rate_share = value[RATE_W-1:0];
                default:       ;
            endcase
        endfunction

        function logic [63:0] sat_mul(logic [63:0] a, logic [63:0] b);
            logic [127:0] p;
            p = {64'd0, a} * {64'd0, b};
            return (p[127:64] != 0) ? '1 : p[63:0];
        endfunction

        function logic [63:0] sat_add(logic [63:0] a, logic [63:0] b);
            logic [64:0] s;
            s = {1'b0, a} + {1'b0, b};
            return s[64] ? '1 : s[63:0];
        endfunction

        // Per-packet gap in nanoseconds; a rate below one packet per second
        // falls back to one second.
        function logic [63:0] gap_ns();
            logic [63:0] goal_bps;
            logic [63:0] wire_bits;
            logic [63:0] pps;
            goal_bps  = (64'(line_rate) * 64'(rate_share)) / HUNDREDTHS_ALL;
            wire_bits = (64'(frame_len) + 64'(WIRE_OVERHEAD_BYTES_DEF)) * 64'd8;
            if (wire_bits == 0)
                return ONE_SECOND_NS;
            pps = goal_bps / wire_bits;
            if (pps == 0)
                return ONE_SECOND_NS;
            return ONE_SECOND_NS / pps;
        endfunction

        // Applies one command to the schedule and statistics and returns
        // the result the block should produce for it.
        function out_item_t pace_outcome(in_item_t req);
            out_item_t   r;
            logic [63:0] batch;
            logic [63:0] limit;
            r = '0;
            case (req.command)
                CMD_PACE:
                begin
                    n_pace++;
                    batch = sat_mul(gap_ns(), 64'(req.count));
                    limit = sat_add(schedule_ns, sat_mul(batch, 64'(OVERRUN_FACTOR_DEF)));
                    r.release_ns = req.now_ns;
                    if (req.now_ns < schedule_ns)
                    begin
                        delay_cnt++;
                        n_waited++;
                        r.waited     = 1'b1;
                        r.release_ns = schedule_ns;
                    end
                    else if (req.now_ns > limit)
                    begin
                        overrun_cnt++;
                        n_resync++;
                        r.overran   = 1'b1;
                        schedule_ns = req.now_ns;
                    end
                    schedule_ns = sat_add(schedule_ns, batch);
                end
                CMD_RECORD:
                begin
                    n_record++;
                    packet_cnt += 64'(req.count);
                    byte_cnt   += 64'(req.byte_count);
                end
                CMD_RESTART:
                begin
                    n_restart++;
                    schedule_ns = req.now_ns;
                    delay_cnt   = '0;
                    overrun_cnt = '0;
                    packet_cnt  = '0;
                    byte_cnt    = '0;
                end
                default:
                    n_nop++;
            endcase
            r.delay_total   = delay_cnt;
            r.overrun_total = overrun_cnt;
            r.packets_total = packet_cnt;
            r.bytes_total   = byte_cnt;
            return r;
        endfunction

        function void note_request(in_item_t req);
            pending_outcomes.push_back(pace_outcome(req));
        endfunction

        function void report_field(string field, logic [63:0] want, logic [63:0] got);
            if (want !== got)
            begin
                faults++;
                if (faults <= 10)
                    $display("%0t: %s mismatch, expected %0h, got %0h", $time, field, want, got);
            end
        endfunction

        function void check_result(out_item_t got);
            out_item_t want;
            if (pending_outcomes.size() == 0)
            begin
                faults++;
                if (faults <= 10)
                    $display("%0t: result arrived with no request outstanding", $time);
                return;
            end
            want = pending_outcomes.pop_front();
            report_field("release_ns", want.release_ns, got.release_ns);
            report_field("waited", 64'(want.waited), 64'(got.waited));
            report_field("overran", 64'(want.overran), 64'(got.overran));
            report_field("delay_total", want.delay_total, got.delay_total);
            report_field("overrun_total", want.overrun_total, got.overrun_total);
            report_field("packets_total", want.packets_total, got.packets_total);
            report_field("bytes_total", want.bytes_total, got.bytes_total);
        endfunction
    endclass

    // Rate settings visited after the reset defaults; the last is random.
    localparam int N_SETTINGS = 8;
    localparam logic [LINE_RATE_W-1:0] LINE_SET [N_SETTINGS] = '{
        39'h7F_FFFF_FFFF, 39'd10000000000, 39'd1, 39'd1000000000,
        39'd1000000000, 39'd0, 39'd400000000000, 39'd0
    };
    localparam logic [FRAME_W-1:0] FRAME_SET [N_SETTINGS] = '{
        15'd64, 15'd32767, 15'd64, 15'd1500, 15'd1500, 15'd0, 15'd9000, 15'd0
    };
    localparam logic [RATE_W-1:0] RATE_SET [N_SETTINGS] = '{
        14'd10000, 14'd10000, 14'd1, 14'd0, 14'd16383, 14'd5000, 14'd10000, 14'd0
    };
    localparam int RANDOM_ITEMS = 50;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = CFG_LINE_RATE;
    logic [CFG_DATA_W-1:0] cfg_data = '0;
    logic                  in_valid = 1'b0;
    logic                  in_ready;
    in_item_t              in_data = '0;
    logic                  out_valid;
    logic                  out_ready = 1'b0;
    out_item_t             out_data;
    logic                  quiet = 1'b0;

    pacing_checker board;

    packet_pacing_gate dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

    always #5 clk = ~clk;

    // Result side stalls at random unless a quiet stretch is running.
    always @(posedge clk)
        out_ready <= quiet || ($urandom_range(0, 99) >= 12);

    // Every returned transaction is checked against the oldest prediction.
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
            board.check_result(out_data);
    end

    function automatic in_item_t make_item(logic [1:0] cmd, logic [63:0] now,
                                           logic [15:0] cnt, logic [31:0] nbytes);
        in_item_t it;
        it.command    = cmd;
        it.now_ns     = now;
        it.count      = cnt;
        it.byte_count = nbytes;
        return it;
    endfunction

    function automatic logic [15:0] pick_count();
        int r;
        r = $urandom_range(0, 99);
        if (r < 5)
            return 16'd0;
        if (r < 10)
            return 16'hFFFF;
        if (r < 30)
            return 16'($urandom);
        return 16'($urandom_range(1, 32));
    endfunction

    // Start time for a restart: mostly moderate, sometimes right below the
    // top of the time range, sometimes anywhere.
    function automatic logic [63:0] pick_base();
        int r;
        r = $urandom_range(0, 9);
        if (r < 8)
            return 64'($urandom) * 64'd1000;
        if (r < 9)
            return '1 - 64'($urandom_range(0, 1000000));
        return {$urandom, $urandom};
    endfunction

    // Presents one transaction and holds it until the block takes it.
    task automatic drive_request(input in_item_t item);
        if (!quiet && $urandom_range(0, 99) < 12)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= item;
        do
            @(posedge clk);
        while (!in_ready);
        board.note_request(item);
    endtask

    // Writes all three registers back to back while the block is idle.
    task automatic apply_setting(input logic [LINE_RATE_W-1:0] line,
                                 input logic [FRAME_W-1:0] frame,
                                 input logic [RATE_W-1:0] rate);
        cfg_wr_en <= 1'b1;
        cfg_index <= CFG_LINE_RATE;
        cfg_data  <= CFG_DATA_W'(line);
        @(posedge clk);
        cfg_index <= CFG_FRAME;
        cfg_data  <= CFG_DATA_W'(frame);
        @(posedge clk);
        cfg_index <= CFG_RATE;
        cfg_data  <= CFG_DATA_W'(rate);
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        board.set_register(CFG_LINE_RATE, CFG_DATA_W'(line));
        board.set_register(CFG_FRAME, CFG_DATA_W'(frame));
        board.set_register(CFG_RATE, CFG_DATA_W'(rate));
        board.n_settings++;
    endtask

    task automatic wait_for_results();
        while (board.pending_outcomes.size() != 0)
            @(posedge clk);
    endtask

    // Boundaries of the schedule, saturation near the top of the time range,
    // zero and full batches, and extreme statistics updates.
    task automatic run_directed();
        logic [63:0] span;
        drive_request(make_item(CMD_NOP, '0, 16'd7, 32'd9));
        drive_request(make_item(CMD_RESTART, 64'd1000, '0, '0));
        drive_request(make_item(CMD_PACE, 64'd500, 16'd1, '0));
        drive_request(make_item(CMD_PACE, board.schedule_ns, 16'd4, '0));
        // Exactly on the overrun threshold, then one past it.
        span = board.gap_ns() * 64'd2 * 64'(OVERRUN_FACTOR_DEF);
        drive_request(make_item(CMD_PACE, board.schedule_ns + span, 16'd2, '0));
        drive_request(make_item(CMD_PACE, board.schedule_ns + span + 1, 16'd2, '0));
        drive_request(make_item(CMD_PACE, board.schedule_ns, 16'd0, '0));
        drive_request(make_item(CMD_PACE, board.schedule_ns + 1, 16'd0, '0));
        drive_request(make_item(CMD_PACE, '0, 16'hFFFF, '0));
        drive_request(make_item(CMD_RECORD, 64'd77, 16'hFFFF, 32'hFFFF_FFFF));
        drive_request(make_item(CMD_RECORD, '0, 16'd0, 32'd0));
        drive_request(make_item(CMD_RECORD, {$urandom, $urandom}, 16'($urandom), $urandom));
        drive_request(make_item(CMD_NOP, '1, 16'hFFFF, 32'hFFFF_FFFF));
        // The schedule saturates at the top of the time range.
        drive_request(make_item(CMD_RESTART, '1 - 64'd100, '0, '0));
        drive_request(make_item(CMD_PACE, '1 - 64'd100, 16'hFFFF, '0));
        drive_request(make_item(CMD_PACE, '1, 16'd1, '0));
        drive_request(make_item(CMD_PACE, '0, 16'd1, '0));
        drive_request(make_item(CMD_RESTART, '0, 16'hFFFF, 32'hFFFF_FFFF));
        drive_request(make_item(CMD_PACE, '1, 16'd1, '0));
        drive_request(make_item(CMD_RECORD, '0, 16'd1, 32'd1));
    endtask

    // Mostly a plausible transmit loop that follows the schedule with random
    // drift, mixed with records, restarts and fully random transactions.
    task automatic run_schedule(input int n);
        logic [63:0] wall;
        in_item_t    req;
        int          pick;
        int          k;
        wall = pick_base();
        drive_request(make_item(CMD_RESTART, wall, 16'($urandom), $urandom));
        repeat (n)
        begin
            pick = $urandom_range(0, 99);
            req  = make_item(CMD_PACE, wall, pick_count(), $urandom);
            if (pick < 8)
            begin
                req.command = 2'($urandom);
                req.now_ns  = {$urandom, $urandom};
            end
            else if (pick < 12)
            begin
                wall           = pick_base();
                req.command    = CMD_RESTART;
                req.now_ns     = wall;
            end
            else if (pick < 32)
            begin
                req.command = CMD_RECORD;
            end
            else
            begin
                // Drift below eight is early, far above it falls behind.
                k = ($urandom_range(0, 9) < 7) ? $urandom_range(0, 12) : $urandom_range(0, 200);
                wall = wall + board.gap_ns() * 64'(req.count) * 64'(k) / 64'd8;
                req.now_ns = wall;
            end
            drive_request(req);
        end
        in_valid <= 1'b0;
    endtask

    // Watchdog for a hung handshake.
    initial
    begin
        #2_000_000;
        $display("[FAIL] regression broken");
        $finish;
    end

    initial
    begin
        board = new();
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset defaults first.
        run_directed();
        run_schedule(RANDOM_ITEMS);

        for (int i = 0; i < N_SETTINGS; i++)
        begin
            wait_for_results();
            if (i == N_SETTINGS - 1)
                apply_setting(LINE_RATE_W'({$urandom, $urandom}), FRAME_W'($urandom),
                              RATE_W'($urandom));
            else
                apply_setting(LINE_SET[i], FRAME_SET[i], RATE_SET[i]);
            // One whole setting runs without any idling on either side.
            quiet = (i == 1);
            run_schedule(RANDOM_ITEMS);
        end

        wait_for_results();
        repeat (20) @(posedge clk);
        board.faults += board.pending_outcomes.size();

        $display("Covered %0d transactions: %0d pace, %0d record, %0d restart, %0d no-op.",
                 board.n_pace + board.n_record + board.n_restart + board.n_nop,
                 board.n_pace, board.n_record, board.n_restart, board.n_nop);
        $display("%0d rate settings written, %0d batches waited, %0d resyncs, %0d faults.",
                 board.n_settings, board.n_waited, board.n_resync, board.faults);
        if (board.faults == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
